### hdl/tcgr_pkg.sv
// Shared types, constants and helpers for the text cursor glyph renderer.
`default_nettype none
package tcgr_pkg;

  // Field widths
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned GLYPH_W   = 64;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned PITCH_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;
  // Pixel row index: row (8 bits) times glyph height (at most 8)
  localparam int unsigned PIX_ROW_W = 11;

  // Defaults
  localparam int unsigned GLYPH_HEIGHT_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  // Register reset values
  localparam logic [PITCH_W-1:0] PITCH_RST   = PITCH_W'(320);
  localparam logic [POS_W-1:0]   MAX_COL_RST = POS_W'(39);
  localparam logic [POS_W-1:0]   MAX_ROW_RST = POS_W'(24);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COL   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW   = CFG_IDX_W'(2);

  // Item actions
  localparam logic ACT_PRINT      = 1'b0;
  localparam logic ACT_SET_CURSOR = 1'b1;

  // Control character codes
  localparam logic [CODE_W-1:0] CHR_NUL = CODE_W'(0);
  localparam logic [CODE_W-1:0] CHR_LF  = CODE_W'(10);
  localparam logic [CODE_W-1:0] CHR_CR  = CODE_W'(13);

  // Byte offset of the high-nibble write within a glyph row
  localparam logic [ADDR_W-1:0] HALF_OFFSET = ADDR_W'(4);

  // One glyph to draw: address of its first pixel row plus its rows
  typedef struct packed {
    logic [ADDR_W-1:0]  base_addr;
    logic [GLYPH_W-1:0] glyph;
  } job_t;

  // Widen four glyph bits into four 0xFF/0x00 pixel bytes, bit 0 in byte 0
  function automatic logic [VALUE_W-1:0] widen_nibble(input logic [3:0] nib);
    logic [VALUE_W-1:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      v[8*k +: 8] = {8{nib[k]}};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/tcgr_ifs.sv
// Channel interfaces: input items, result words and register writes.
`default_nettype none

interface tcgr_in_if
  import tcgr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [CODE_W-1:0]  char_code;
  logic [GLYPH_W-1:0] glyph_rows;
  logic [POS_W-1:0]   new_column;
  logic [POS_W-1:0]   new_row;

  modport source (output valid, action, char_code, glyph_rows, new_column, new_row,
                  input ready);
  modport sink (input valid, action, char_code, glyph_rows, new_column, new_row,
                output ready);
endinterface

interface tcgr_out_if
  import tcgr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  write_address;
  logic [VALUE_W-1:0] write_value;
  logic               last_write;

  modport source (output valid, write_address, write_value, last_write, input ready);
  modport sink (input valid, write_address, write_value, last_write, output ready);
endinterface

interface tcgr_cfg_if
  import tcgr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/tcgr_front.sv
// Front end: registers, cursor state, item classification and job address.
`default_nettype none
module tcgr_front
  import tcgr_pkg::*;
#(
  parameter int unsigned GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tcgr_in_if.sink          in_ch,
  tcgr_cfg_if.sink         cfg_ch,
  output logic             push_valid,
  input  wire logic        push_ready,
  output job_t             push_job,
  output logic [PITCH_W-1:0] pitch
);

  logic [PITCH_W-1:0]  pitch_r;
  logic [POS_W-1:0]    max_col_r, max_row_r;
  logic [POS_W-1:0]    col_r, col_nxt;
  logic [POS_W-1:0]    row_r, row_nxt;
  logic [POS_W-1:0]    row_adv;
  logic [PIX_ROW_W-1:0] pix_row;
  logic [ADDR_W-1:0]   row_off;
  logic [ADDR_W-1:0]   col_off;
  logic                accept;
  logic                printable;

  assign in_ch.ready  = push_ready;
  assign cfg_ch.ready = 1'b1;
  assign pitch        = pitch_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r   <= PITCH_RST;
      max_col_r <= MAX_COL_RST;
      max_row_r <= MAX_ROW_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROW_PITCH: pitch_r   <= cfg_ch.data;
        REG_MAX_COL:   max_col_r <= cfg_ch.data[POS_W-1:0];
        REG_MAX_ROW:   max_row_r <= cfg_ch.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the item and work out the next cursor
  always_comb begin
    accept    = in_ch.valid && push_ready;
    printable = (in_ch.action == ACT_PRINT) && (in_ch.char_code != CHR_NUL) &&
                (in_ch.char_code != CHR_LF) && (in_ch.char_code != CHR_CR);
    row_adv   = (row_r >= max_row_r) ? '0 : row_r + POS_W'(1);
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept) begin
      if (in_ch.action == ACT_SET_CURSOR) begin
        col_nxt = in_ch.new_column;
        row_nxt = in_ch.new_row;
      end else if (in_ch.char_code == CHR_LF) begin
        col_nxt = '0;
        row_nxt = row_adv;
      end else if (in_ch.char_code == CHR_CR) begin
        col_nxt = '0;
      end else if (printable) begin
        if (col_r >= max_col_r) begin
          col_nxt = '0;
          row_nxt = row_adv;
        end else begin
          col_nxt = col_r + POS_W'(1);
        end
      end
    end
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // First pixel byte of the cell: column*8 + row*height*pitch
  always_comb begin
    pix_row = PIX_ROW_W'(row_r) * PIX_ROW_W'(GLYPH_HEIGHT);
    row_off = ADDR_W'(pix_row) * ADDR_W'(pitch_r);
    col_off = ADDR_W'({col_r, 3'b000});
  end

  assign push_valid         = in_ch.valid && printable;
  assign push_job.base_addr = col_off + row_off;
  assign push_job.glyph     = in_ch.glyph_rows;

endmodule
`default_nettype wire

### hdl/tcgr_queue.sv
// Short job queue between the front end and the write generator.
`default_nettype none
module tcgr_queue
  import tcgr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/tcgr_back.sv
// Write generator: turns one glyph job into two words per glyph row.
`default_nettype none
module tcgr_back
  import tcgr_pkg::*;
#(
  parameter int unsigned GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire job_t               pop_job,
  input  wire logic [PITCH_W-1:0] pitch,
  tcgr_out_if.source              out_ch
);

  localparam int unsigned CNT_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  logic               busy_r, busy_nxt;
  logic [ADDR_W-1:0]  row_addr_r, row_addr_nxt;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic               half_r, half_nxt;
  logic [CNT_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               emit, final_word;

  // Step through the words of the current job
  always_comb begin
    emit          = busy_r && (!out_valid_r || out_ch.ready);
    final_word    = half_r && (row_cnt_r == CNT_W'(GLYPH_HEIGHT - 1));
    pop_ready     = !busy_r || (emit && final_word);
    busy_nxt      = busy_r;
    row_addr_nxt  = row_addr_r;
    glyph_nxt     = glyph_r;
    half_nxt      = half_r;
    row_cnt_nxt   = row_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_addr_nxt  = out_addr_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = final_word;
      if (half_r) begin
        out_addr_nxt  = row_addr_r + HALF_OFFSET;
        out_value_nxt = widen_nibble(glyph_r[7:4]);
        row_addr_nxt  = row_addr_r + ADDR_W'(pitch);
        glyph_nxt     = {8'h00, glyph_r[GLYPH_W-1:8]};
        row_cnt_nxt   = row_cnt_r + CNT_W'(1);
        half_nxt      = 1'b0;
        if (final_word) begin
          busy_nxt = 1'b0;
        end
      end else begin
        out_addr_nxt  = row_addr_r;
        out_value_nxt = widen_nibble(glyph_r[3:0]);
        half_nxt      = 1'b1;
      end
    end

    // Take the next job as soon as the current one is done
    if (pop_ready && pop_valid) begin
      busy_nxt     = 1'b1;
      row_addr_nxt = pop_job.base_addr;
      glyph_nxt    = pop_job.glyph;
      half_nxt     = 1'b0;
      row_cnt_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
      row_cnt_r   <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
      row_cnt_r   <= row_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_addr_r  <= row_addr_nxt;
    glyph_r     <= glyph_nxt;
    out_addr_r  <= out_addr_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_address = out_addr_r;
  assign out_ch.write_value   = out_value_r;
  assign out_ch.last_write    = out_last_r;

endmodule
`default_nettype wire

### hdl/text_cursor_glyph_renderer.sv
// Top level of the text cursor glyph renderer.
// Text-mode renderer with a character cursor. Each printable character
// produces 2*GLYPH_HEIGHT 32-bit frame-buffer writes (16 by default), one
// per cycle on out_ch unless the sink stalls, low nibble of each glyph
// row first; last_write marks the final word. The write generator sets
// the rate and leaves no gap between characters while jobs are queued.
// Set-cursor items and the control codes (newline, carriage return, zero)
// produce no writes; they pass the front end while the previous character
// is still being drawn, as long as the job queue has a free slot.
// Registers: index 0 row pitch in bytes, 1 last column, 2 last row; write
// them only while idle.
`default_nettype none
module text_cursor_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int unsigned GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcgr_in_if.sink    in_ch,
  tcgr_cfg_if.sink   cfg_ch,
  tcgr_out_if.source out_ch
);

  logic               push_valid, push_ready;
  job_t               push_job;
  logic               pop_valid, pop_ready;
  job_t               pop_job;
  logic [PITCH_W-1:0] pitch;

  // Cursor, registers and classification
  tcgr_front #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pitch     (pitch)
  );

  // Job queue
  tcgr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  // Write generation
  tcgr_back #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .pitch    (pitch),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

### test/tb_text_cursor_glyph_renderer.sv
// Testbench for the text cursor glyph renderer: cursor and glyph write prediction with checks.
module tb_text_cursor_glyph_renderer;
  import tcgr_pkg::*;

  localparam int GH = GLYPH_HEIGHT_DEF;
  // index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic               action;
    logic [CODE_W-1:0]  code;
    logic [GLYPH_W-1:0] glyph;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } char_item_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic               last;
  } fb_write_t;

  logic clk;
  logic rst_n;

  tcgr_in_if  in_ch ();
  tcgr_cfg_if cfg_ch ();
  tcgr_out_if out_ch ();

  text_cursor_glyph_renderer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Predicted registers and cursor
  logic [PITCH_W-1:0] pitch_r   = PITCH_RST;
  logic [POS_W-1:0]   max_col_r = MAX_COL_RST;
  logic [POS_W-1:0]   max_row_r = MAX_ROW_RST;
  logic [POS_W-1:0]   cur_col   = '0;
  logic [POS_W-1:0]   cur_row   = '0;

  char_item_t send_q[$];
  fb_write_t  write_q[$];
  char_item_t cur_item;

  int items_queued   = 0;
  int items_accepted = 0;
  int writes_seen    = 0;
  int errors         = 0;
  int send_idle_pct  = 24;
  int recv_stall_pct = 24;
  int hold_left      = 0;
  bit hold_done      = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Four glyph bits to four pixel bytes, bit 0 in the low byte
  function automatic logic [VALUE_W-1:0] nibble_pixels(input logic [3:0] nib);
    logic [VALUE_W-1:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if (nib[k]) v[8*k +: 8] = 8'hFF;
    end
    return v;
  endfunction

  function automatic logic [POS_W-1:0] next_row(input logic [POS_W-1:0] row);
    return (row >= max_row_r) ? '0 : row + 1'b1;
  endfunction

  // Update the cursor for one item and queue the frame-buffer writes it causes
  task automatic predict_writes(input char_item_t it);
    logic [31:0] addr;
    logic [7:0]  line;
    fb_write_t   w;
    if (it.action == ACT_SET_CURSOR) begin
      cur_col = it.col;
      cur_row = it.row;
    end else if (it.code == CHR_LF) begin
      cur_col = '0;
      cur_row = next_row(cur_row);
    end else if (it.code == CHR_CR) begin
      cur_col = '0;
    end else if (it.code != CHR_NUL) begin
      for (int r = 0; r < GH; r++) begin
        line = it.glyph[8*r +: 8];
        addr = 32'(cur_col) * 8 + (32'(cur_row) * GH + r) * 32'(pitch_r);
        w.addr  = addr[ADDR_W-1:0];
        w.value = nibble_pixels(line[3:0]);
        w.last  = 1'b0;
        write_q.push_back(w);
        addr = addr + 32'(HALF_OFFSET);
        w.addr  = addr[ADDR_W-1:0];
        w.value = nibble_pixels(line[7:4]);
        w.last  = (r == GH - 1);
        write_q.push_back(w);
      end
      if (cur_col >= max_col_r) begin
        cur_col = '0;
        cur_row = next_row(cur_row);
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end
  endtask

  // Input driver: offers queued items, predicts on each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_writes(cur_item);
        items_accepted <= items_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = send_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= cur_item.action;
          in_ch.char_code  <= cur_item.code;
          in_ch.glyph_rows <= cur_item.glyph;
          in_ch.new_column <= cur_item.col;
          in_ch.new_row    <= cur_item.row;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the run is well under way
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && items_accepted >= 100) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Output monitor: compares each accepted write with the oldest prediction
  always @(posedge clk) begin
    fb_write_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (write_q.size() == 0) begin
          errors++;
          $display("%0t: write expected none, actual addr %h value %h last %b", $time,
                   out_ch.write_address, out_ch.write_value, out_ch.last_write);
        end else begin
          w = write_q.pop_front();
          if (out_ch.write_address !== w.addr) begin
            errors++;
            $display("%0t: write %0d address expected %h actual %h", $time, writes_seen,
                     w.addr, out_ch.write_address);
          end
          if (out_ch.write_value !== w.value) begin
            errors++;
            $display("%0t: write %0d value expected %h actual %h", $time, writes_seen,
                     w.value, out_ch.write_value);
          end
          if (out_ch.last_write !== w.last) begin
            errors++;
            $display("%0t: write %0d last expected %b actual %b", $time, writes_seen,
                     w.last, out_ch.last_write);
          end
        end
        writes_seen++;
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic char_item_t glyph_char(input logic [CODE_W-1:0] code,
                                            input logic [GLYPH_W-1:0] glyph);
    char_item_t it;
    it.action = ACT_PRINT;
    it.code   = code;
    it.glyph  = glyph;
    it.col    = POS_W'($urandom);
    it.row    = POS_W'($urandom);
    return it;
  endfunction

  function automatic char_item_t cursor_to(input logic [POS_W-1:0] col,
                                           input logic [POS_W-1:0] row);
    char_item_t it;
    it.action = ACT_SET_CURSOR;
    it.code   = CODE_W'($urandom);
    it.glyph  = {$urandom, $urandom};
    it.col    = col;
    it.row    = row;
    return it;
  endfunction

  // Mostly printable characters, some cursor moves and control codes
  function automatic char_item_t random_item();
    char_item_t it;
    int sel;
    it = glyph_char(CODE_W'($urandom), {$urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 12) begin
      it.action = ACT_SET_CURSOR;
      if ($urandom_range(3) != 0) begin
        it.col = POS_W'($urandom_range(max_col_r));
        it.row = POS_W'($urandom_range(max_row_r));
      end
    end else if (sel < 18) begin
      it.code = CHR_LF;
    end else if (sel < 22) begin
      it.code = CHR_CR;
    end else if (sel < 24) begin
      it.code = CHR_NUL;
    end else begin
      while (it.code inside {CHR_NUL, CHR_LF, CHR_CR}) it.code = CODE_W'($urandom);
      if (sel >= 94) it.glyph = sel[0] ? '1 : '0;
    end
    return it;
  endfunction

  task automatic push_item(input char_item_t it);
    send_q.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while ((items_accepted != items_queued || write_q.size() != 0) && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ROW_PITCH: pitch_r   = data;
      REG_MAX_COL:   max_col_r = data[POS_W-1:0];
      REG_MAX_ROW:   max_row_r = data[POS_W-1:0];
      default: ;
    endcase
  endtask

  // New register setting, then a batch of random items
  task automatic run_phase(input logic [PITCH_W-1:0] pitch, input logic [POS_W-1:0] mcol,
                           input logic [POS_W-1:0] mrow, input int n_items,
                           input int idle_pct);
    write_reg(REG_ROW_PITCH, pitch);
    write_reg(REG_MAX_COL, {5'($urandom), mcol});
    write_reg(REG_MAX_ROW, {5'($urandom), mrow});
    send_idle_pct  = idle_pct;
    recv_stall_pct = idle_pct;
    repeat (n_items) push_item(random_item());
    wait_drained();
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PRINT;
    in_ch.char_code = '0;
    in_ch.glyph_rows = '0;
    in_ch.new_column = '0;
    in_ch.new_row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROW_PITCH;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: glyph extremes, wraps, cursor past the limits, control codes
    push_item(glyph_char(8'h41, '1));
    push_item(glyph_char(8'hFF, '0));
    push_item(glyph_char(8'h01, 64'h0123_4567_89AB_CDEF));
    push_item(cursor_to(MAX_COL_RST, MAX_ROW_RST));
    push_item(glyph_char(8'h80, 64'hA5A5_5A5A_F0F0_0F0F));
    push_item(glyph_char(8'h7E, 64'hFEDC_BA98_7654_3210));
    push_item(cursor_to(8'hFF, 8'hFF));
    push_item(glyph_char(8'h42, 64'h8040_2010_0804_0201));
    push_item(glyph_char(CHR_CR, {$urandom, $urandom}));
    push_item(glyph_char(8'h43, {$urandom, $urandom}));
    push_item(glyph_char(CHR_LF, {$urandom, $urandom}));
    push_item(glyph_char(8'h44, {$urandom, $urandom}));
    push_item(glyph_char(CHR_NUL, '1));
    push_item(glyph_char(8'h45, {$urandom, $urandom}));
    push_item(cursor_to(8'd0, MAX_ROW_RST));
    push_item(glyph_char(CHR_LF, '1));
    push_item(glyph_char(8'h46, {$urandom, $urandom}));
    push_item(cursor_to(8'd5, 8'd3));
    push_item(glyph_char(8'h0B, {$urandom, $urandom}));
    push_item(glyph_char(8'h0E, {$urandom, $urandom}));
    wait_drained();

    // random phases over several settings, the extremes among them
    run_phase(PITCH_W'(1), 8'd0, 8'd0, 50, 24);
    run_phase('1, 8'd255, 8'd255, 80, 0);
    write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
    run_phase('0, 8'd7, 8'd3, 50, 24);
    run_phase(PITCH_W'(4096), 8'd39, 8'd24, 60, 24);
    run_phase(PITCH_W'($urandom_range(1, 4096)), POS_W'($urandom), POS_W'($urandom), 70, 24);

    if (items_accepted != items_queued || write_q.size() != 0) begin
      errors++;
      $display("%0t: %0d items not taken, %0d writes missing", $time,
               items_queued - items_accepted, write_q.size());
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hdl/tcgr_pkg.sv
hdl/tcgr_ifs.sv
hdl/tcgr_front.sv
hdl/tcgr_queue.sv
hdl/tcgr_back.sv
hdl/text_cursor_glyph_renderer.sv
test/tb_text_cursor_glyph_renderer.sv
